// ===== hw/rtl/esdt_pkg.sv =====
// Shared types and constants for the epoch seconds to date and time core.
// Holds the result structs, the reciprocal constants and the month tables.
// No dependencies.
package esdt_pkg;

  localparam int unsigned SECONDS_W = 32;
  localparam int unsigned DAYS_W    = 16;
  localparam int unsigned SOD_W     = 17;
  localparam int unsigned DIB_W     = 11;
  localparam int unsigned DOY_W     = 9;

  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [15:0] DAYS_PER_BLK  = 16'd1461;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [11:0] SECS_PER_MIN  = 12'd60;
  localparam logic [10:0] BASE_YEAR     = 11'd1904;

  // floor(x / 86400) = floor((x >> 7) * DAY_RECIP >> DAY_SHIFT) for 32-bit x
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  localparam int unsigned DAY_SHIFT  = 35;
  // floor(d / 1461) for d below 2^16
  localparam logic [16:0] BLK_RECIP  = 17'd91868;
  localparam int unsigned BLK_SHIFT  = 27;
  // floor(s / 3600) = floor((s >> 4) * HOUR_RECIP >> HOUR_SHIFT)
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  localparam int unsigned HOUR_SHIFT = 21;
  // floor(r / 60) = floor((r >> 2) * MIN_RECIP >> MIN_SHIFT)
  localparam logic [10:0] MIN_RECIP  = 11'd1093;
  localparam int unsigned MIN_SHIFT  = 14;

  // first day of each month, zero-based day of year
  localparam logic [DOY_W-1:0] CUM_LEAP [12] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };
  localparam logic [DOY_W-1:0] CUM_COMMON [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

endpackage

// ===== hw/rtl/esdt_day_split.sv =====
// Splits a seconds count into whole days and seconds of the day.
// Two register stages: reciprocal product, then days and remainder.
// Depends on esdt_pkg.
module esdt_day_split (
  input  logic                            clk,
  input  logic                            en,
  input  logic [esdt_pkg::SECONDS_W-1:0]  seconds,
  output logic [esdt_pkg::DAYS_W-1:0]     days,
  output logic [esdt_pkg::SOD_W-1:0]      sod
);
  import esdt_pkg::*;

  logic [SECONDS_W-1:0] secs1;
  logic [50:0]          prod1;
  logic [DAYS_W-1:0]    days_next;
  logic [31:0]          day_base;

  assign days_next = prod1[DAY_SHIFT +: DAYS_W];
  assign day_base  = 32'(days_next) * SECS_PER_DAY;

  always_ff @(posedge clk) begin
    if (en) begin
      secs1 <= seconds;
      prod1 <= 51'(seconds[31:7]) * 51'(DAY_RECIP);
      days  <= days_next;
      sod   <= SOD_W'(secs1 - day_base);
    end
  end

endmodule

// ===== hw/rtl/esdt_date.sv =====
// Resolves a day count into year, month and day of month.
// Four register stages: block product, block split, year split, month lookup.
// Depends on esdt_pkg.
module esdt_date (
  input  logic                        clk,
  input  logic                        en,
  input  logic [esdt_pkg::DAYS_W-1:0] days,
  output esdt_pkg::date_t             date
);
  import esdt_pkg::*;

  logic [DAYS_W-1:0]  days3;
  logic [32:0]        pb3;
  logic [5:0]         blocks_next;
  logic [5:0]         blocks4;
  logic [DIB_W-1:0]   dib4;
  logic [5:0]         blocks5;
  logic [1:0]         yib5;
  logic [DOY_W-1:0]   doy5;
  logic               leap5;
  logic [1:0]         yib_next;
  logic [DOY_W-1:0]   doy_next;
  logic               leap_next;
  logic [DIB_W-1:0]   dib_less;
  logic [3:0]         month_next;
  logic [DOY_W-1:0]   first_next;
  date_t              date_next;

  assign blocks_next = pb3[BLK_SHIFT +: 6];
  assign dib_less    = dib4 - 11'd1;

  always_comb begin
    leap_next = 1'b0;
    yib_next  = 2'd1;
    doy_next  = DOY_W'(dib_less - 11'd365);
    if (dib4 < 11'd366) begin
      leap_next = 1'b1;
      yib_next  = 2'd0;
      doy_next  = dib4[DOY_W-1:0];
    end else if (dib_less >= 11'd1095) begin
      yib_next = 2'd3;
      doy_next = DOY_W'(dib_less - 11'd1095);
    end else if (dib_less >= 11'd730) begin
      yib_next = 2'd2;
      doy_next = DOY_W'(dib_less - 11'd730);
    end
  end

  always_comb begin
    month_next = 4'd1;
    first_next = '0;
    for (int i = 1; i < 12; i++) begin
      if (doy5 >= (leap5 ? CUM_LEAP[i] : CUM_COMMON[i])) begin
        month_next = 4'(i + 1);
        first_next = leap5 ? CUM_LEAP[i] : CUM_COMMON[i];
      end
    end
    date_next.year  = BASE_YEAR + {3'b0, blocks5, 2'b00} + {9'b0, yib5};
    date_next.month = month_next;
    date_next.day   = 5'(doy5 - first_next) + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      days3   <= days;
      pb3     <= 33'(days) * 33'(BLK_RECIP);
      blocks4 <= blocks_next;
      dib4    <= DIB_W'(days3 - 16'(blocks_next) * DAYS_PER_BLK);
      blocks5 <= blocks4;
      yib5    <= yib_next;
      doy5    <= doy_next;
      leap5   <= leap_next;
      date    <= date_next;
    end
  end

endmodule

// ===== hw/rtl/esdt_clock.sv =====
// Resolves seconds of the day into hour, minute and second.
// Four register stages: hour product, hour split, minute product, minute split.
// Depends on esdt_pkg.
module esdt_clock (
  input  logic                       clk,
  input  logic                       en,
  input  logic [esdt_pkg::SOD_W-1:0] sod,
  output esdt_pkg::hms_t             hms
);
  import esdt_pkg::*;

  logic [SOD_W-1:0] sod3;
  logic [26:0]      ph3;
  logic [4:0]       hour_next;
  logic [4:0]       hour4;
  logic [11:0]      rs4;
  logic [4:0]       hour5;
  logic [11:0]      rs5;
  logic [20:0]      pm5;
  logic [5:0]       minute_next;
  hms_t             hms_next;

  assign hour_next   = ph3[HOUR_SHIFT +: 5];
  assign minute_next = pm5[MIN_SHIFT +: 6];

  always_comb begin
    hms_next.hour   = hour5;
    hms_next.minute = minute_next;
    hms_next.second = 6'(rs5 - 12'(minute_next) * SECS_PER_MIN);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sod3  <= sod;
      ph3   <= 27'(sod[16:4]) * 27'(HOUR_RECIP);
      hour4 <= hour_next;
      rs4   <= 12'(sod3 - 17'(hour_next) * SECS_PER_HOUR);
      hour5 <= hour4;
      rs5   <= rs4;
      pm5   <= 21'(rs4[11:2]) * 21'(MIN_RECIP);
      hms   <= hms_next;
    end
  end

endmodule

// ===== hw/rtl/epoch_seconds_to_date_time_core.sv =====
// Converts a 32-bit count of seconds since midnight 1 January 1904 into
// calendar year, month, day, hour, minute and second, valid to 2040. The
// core takes one word per cycle while the output is not stalled; the pipeline
// holds an input register and the reciprocal multiplications for the day,
// block, hour and minute splits, each followed by a register. A stall on the
// output holds the whole pipeline, and s_axis_tready follows it.
module epoch_seconds_to_date_time_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] seconds
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [10:0] year, [14:11] month, [19:15] day,
                                     // [24:20] hour, [30:25] minute,
                                     // [36:31] second, [39:37] zero
);
  import esdt_pkg::*;

  localparam int unsigned DEPTH = 7;

  logic                 adv;
  logic [DEPTH-1:0]     vld;
  logic [SECONDS_W-1:0] secs0;
  logic [DAYS_W-1:0]    days;
  logic [SOD_W-1:0]     sod;
  date_t                date;
  hms_t                 hms;

  assign adv           = !vld[DEPTH-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      secs0 <= s_axis_tdata;
    end
  end

  esdt_day_split u_day_split (
    .clk     (clk),
    .en      (adv),
    .seconds (secs0),
    .days    (days),
    .sod     (sod)
  );

  esdt_date u_date (
    .clk  (clk),
    .en   (adv),
    .days (days),
    .date (date)
  );

  esdt_clock u_clock (
    .clk (clk),
    .en  (adv),
    .sod (sod),
    .hms (hms)
  );

  assign m_axis_tdata = {3'b000, hms.second, hms.minute, hms.hour,
                         date.day, date.month, date.year};

`ifndef NO_ASSERTIONS
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (date.month >= 4'd1 && date.month <= 4'd12))
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (date.day >= 5'd1 && date.day <= 5'd31))
    else $error("day out of range");

  a_year_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (date.year >= 11'd1904 && date.year <= 11'd2040))
    else $error("year out of range");

  a_clock_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (hms.hour <= 5'd23 && hms.minute <= 6'd59 && hms.second <= 6'd59))
    else $error("time of day out of range");
`endif

endmodule

// ===== bench/tb.sv =====
// Testbench for epoch_seconds_to_date_time_core: drives timestamps on the input
// stream and checks each date and time word against an in-bench calendar model.
// Depends only on the core RTL.
module tb;

  localparam int unsigned BLOCK_SECS = 126230400;
  localparam int unsigned YEAR_SECS  = 31536000;
  localparam int unsigned DAY_SECS   = 86400;
  localparam int unsigned HOUR_SECS  = 3600;
  localparam int unsigned MIN_SECS   = 60;
  localparam int unsigned FIRST_YEAR = 1904;
  localparam int unsigned DAYS_COMMON [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned DAYS_LEAP   [12] = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int STALL_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int ITEMS_PER_PHASE = 400;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  class date_scoreboard;
    calendar_t pending_dates[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    function calendar_t calendar_of(logic [31:0] secs);
      int unsigned blocks, rem, years, doy, hours, mins, m;
      bit leap;
      calendar_t c;
      blocks = secs / BLOCK_SECS;
      rem = secs - blocks * BLOCK_SECS;
      years = 0;
      leap = (rem <= YEAR_SECS);
      if (!leap) begin
        rem = rem - DAY_SECS;
        years = rem / YEAR_SECS;
        rem = rem - years * YEAR_SECS;
      end
      doy = rem / DAY_SECS;
      rem = rem - doy * DAY_SECS;
      for (m = 0; m < 11; m++) begin
        if (doy < (leap ? DAYS_LEAP[m] : DAYS_COMMON[m])) break;
        doy = doy - (leap ? DAYS_LEAP[m] : DAYS_COMMON[m]);
      end
      hours = rem / HOUR_SECS;
      rem = rem - hours * HOUR_SECS;
      mins = rem / MIN_SECS;
      rem = rem - mins * MIN_SECS;
      c.year   = 11'(FIRST_YEAR + blocks * 4 + years);
      c.month  = 4'(m + 1);
      c.day    = 5'(doy + 1);
      c.hour   = 5'(hours);
      c.minute = 6'(mins);
      c.second = 6'(rem);
      return c;
    endfunction

    function void note_seconds(logic [31:0] secs);
      pending_dates.push_back(calendar_of(secs));
    endfunction

    function void check_word(logic [39:0] word);
      calendar_t want, got;
      got.year   = word[10:0];
      got.month  = word[14:11];
      got.day    = word[19:15];
      got.hour   = word[24:20];
      got.minute = word[30:25];
      got.second = word[36:31];
      if (pending_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected word %h", word);
        return;
      end
      want = pending_dates.pop_front();
      if (got.year != want.year || got.month != want.month || got.day != want.day ||
          got.hour != want.hour || got.minute != want.minute ||
          got.second != want.second || word[39:37] != 3'b000) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: expected %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d pad %b",
                   want.year, want.month, want.day, want.hour, want.minute, want.second,
                   got.year, got.month, got.day, got.hour, got.minute, got.second,
                   word[39:37]);
      end
    endfunction

    function int pending();
      return pending_dates.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_cycles = 0;
  date_scoreboard sb = new();

  always #10 clk = ~clk;

  epoch_seconds_to_date_time_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_seconds(logic [31:0] secs);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= secs;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_seconds(secs);
  endtask

  // bias towards year and day boundaries, keep some fully random words
  function automatic logic [31:0] pick_seconds();
    longint unsigned v;
    int unsigned yr_starts [5];
    yr_starts = '{0, YEAR_SECS, YEAR_SECS + DAY_SECS, 2 * YEAR_SECS + DAY_SECS,
                  3 * YEAR_SECS + DAY_SECS};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5: v = longint'($urandom_range(0, 34)) * BLOCK_SECS
                + yr_starts[$urandom_range(0, 4)] + $urandom_range(0, 2 * DAY_SECS)
                - DAY_SECS;
      6, 7: v = longint'($urandom_range(0, 49710)) * DAY_SECS
                + $urandom_range(0, 2 * HOUR_SECS) - HOUR_SECS;
      8: v = 32'hFFFF_FFFF - $urandom_range(0, 200000000);
      default: v = $urandom_range(0, 400000);
    endcase
    return v[31:0];
  endfunction

  initial begin
    logic [31:0] directed [$];
    directed = '{
      32'd0, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
      YEAR_SECS, YEAR_SECS - 1, YEAR_SECS + 1, YEAR_SECS + DAY_SECS - 1,
      YEAR_SECS + DAY_SECS, 2 * YEAR_SECS + DAY_SECS - 1, 2 * YEAR_SECS + DAY_SECS,
      BLOCK_SECS - 1, BLOCK_SECS, BLOCK_SECS + YEAR_SECS,
      59 * DAY_SECS - 1, 59 * DAY_SECS, 60 * DAY_SECS,
      BLOCK_SECS + YEAR_SECS + DAY_SECS + 59 * DAY_SECS - 1,
      BLOCK_SECS + YEAR_SECS + DAY_SECS + 59 * DAY_SECS,
      DAY_SECS - 1, HOUR_SECS - 1, MIN_SECS - 1, MIN_SECS,
      34 * BLOCK_SECS - 1, 34 * BLOCK_SECS
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 13;
    rx_idle_pct = 75;
    foreach (directed[i]) send_seconds(directed[i]);
    repeat (ITEMS_PER_PHASE) send_seconds(pick_seconds());

    tx_idle_pct = 75;
    rx_idle_pct = 13;
    repeat (ITEMS_PER_PHASE) send_seconds(pick_seconds());

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (ITEMS_PER_PHASE) send_seconds(pick_seconds());
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/esdt_pkg.sv
hw/rtl/esdt_day_split.sv
hw/rtl/esdt_date.sv
hw/rtl/esdt_clock.sv
hw/rtl/epoch_seconds_to_date_time_core.sv
bench/tb.sv
